/* hw/rtl/lfu_pkg.sv */
// Shared constants and types for the LFU cache table.
package lfu_pkg;

    localparam int ENTRIES    = 4;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam t_count COUNT_MAX = '1;
    localparam t_count COUNT_ONE = COUNT_BITS'(1);

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;
        logic commit;
    } t_dp_cmd;

endpackage

/* hw/rtl/lfu_if.sv */
// Request and response channel interfaces of the LFU cache table.
interface lfu_req_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    lfu_pkg::t_key        key;
    lfu_pkg::t_value      value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    lfu_pkg::t_value      read_value;
    logic                 evicted;
    lfu_pkg::t_key        evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

/* hw/rtl/lfu_ctrl.sv */
// Controller: sequences capture, table update and response handoff.
module lfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic             i_rsp_ready,
    output logic             o_rsp_valid,
    output lfu_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   commit;

    assign o_req_ready    = (r_state == S_IDLE);
    assign o_rsp_valid    = r_rsp_valid;
    // Update only when the response register is free or being drained.
    assign commit         = (r_state == S_EXEC) && (!r_rsp_valid || i_rsp_ready);
    assign o_cmd.load_req = i_req_valid && (r_state == S_IDLE);
    assign o_cmd.commit   = commit;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

/* hw/rtl/lfu_dpath.sv */
// Datapath: entry table, key match, victim selection and response registers.
module lfu_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfu_pkg::t_dp_cmd  i_cmd,
    input  logic              i_func,
    input  lfu_pkg::t_key     i_key,
    input  lfu_pkg::t_value   i_value,
    output logic              o_hit,
    output lfu_pkg::t_value   o_read_value,
    output logic              o_evicted,
    output lfu_pkg::t_key     o_evicted_key
);

    // Captured request
    logic              r_func;
    lfu_pkg::t_key     r_key;
    lfu_pkg::t_value   r_value;

    // Entry table
    logic [lfu_pkg::ENTRIES-1:0] r_valid;
    lfu_pkg::t_key     r_ent_key   [lfu_pkg::ENTRIES];
    lfu_pkg::t_value   r_ent_value [lfu_pkg::ENTRIES];
    lfu_pkg::t_count   r_count     [lfu_pkg::ENTRIES];
    lfu_pkg::t_idx     r_rank      [lfu_pkg::ENTRIES];

    // Response registers
    logic              r_hit;
    lfu_pkg::t_value   r_read_value;
    logic              r_evicted;
    lfu_pkg::t_key     r_evicted_key;

    logic              match_found;
    lfu_pkg::t_idx     match_idx;
    lfu_pkg::t_idx     vic_idx;
    lfu_pkg::t_idx     free_idx;
    lfu_pkg::t_idx     ins_idx;
    logic              full;
    logic              do_insert;
    logic              do_evict;

    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        free_idx    = '0;
        // Walk downward so the lowest-numbered slot wins.
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_ent_key[i] == r_key)) begin
                match_found = 1'b1;
                match_idx   = lfu_pkg::IDX_BITS'(i);
            end
            if (!r_valid[i]) begin
                free_idx = lfu_pkg::IDX_BITS'(i);
            end
        end
        // Lowest count; on a tie the newest insertion (smaller rank).
        vic_idx = '0;
        for (int i = 1; i < lfu_pkg::ENTRIES; i++) begin
            if ((r_count[i] < r_count[vic_idx]) ||
                ((r_count[i] == r_count[vic_idx]) && (r_rank[i] < r_rank[vic_idx]))) begin
                vic_idx = lfu_pkg::IDX_BITS'(i);
            end
        end
        full      = &r_valid;
        ins_idx   = full ? vic_idx : free_idx;
        do_insert = !match_found && (r_func == lfu_pkg::FUNC_PUT);
        do_evict  = do_insert && full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cmd.commit && do_insert) begin
            // Age the survivors; entries older than the victim keep their rank.
            for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
                if (r_valid[j] && !(full && (r_rank[j] > r_rank[vic_idx]))) begin
                    r_rank[j] <= r_rank[j] + lfu_pkg::IDX_BITS'(1);
                end
            end
            r_valid[ins_idx] <= 1'b1;
            r_rank[ins_idx]  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.commit) begin
            if (match_found) begin
                if (r_func == lfu_pkg::FUNC_PUT) begin
                    r_ent_value[match_idx] <= r_value;
                end
                if (r_count[match_idx] != lfu_pkg::COUNT_MAX) begin
                    r_count[match_idx] <= r_count[match_idx] + lfu_pkg::COUNT_ONE;
                end
            end else if (do_insert) begin
                r_ent_key[ins_idx]   <= r_key;
                r_ent_value[ins_idx] <= r_value;
                r_count[ins_idx]     <= lfu_pkg::COUNT_ONE;
            end
            r_hit         <= match_found;
            r_read_value  <= (match_found && (r_func == lfu_pkg::FUNC_GET))
                             ? r_ent_value[match_idx] : '0;
            r_evicted     <= do_evict;
            r_evicted_key <= do_evict ? r_ent_key[vic_idx] : '0;
        end
    end

    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

/* hw/rtl/lfu_cache_table.sv */
// LFU cache table: fully associative key-value cache with LFU replacement.
//
// Requests arrive on i_req (func, key, value) with a valid/ready handshake;
// func selects get or put. Each request yields exactly one response on
// o_rsp (hit, read_value, evicted, evicted_key), in request order.
// A request is captured at the edge that accepts it, and the table is
// updated at the first later edge at which the response register is free
// or being drained; the response is registered with that update. No new
// request is taken before that update. Match, minimum count search and
// entry table update are combinational, fed by the capture register.
// The response sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the next request is held in the
// capture register until the response register drains, and i_req.ready
// stays low meanwhile.
// Reset (synchronous, active low) empties the table and drops any pending
// response; no clearing pass is needed.
module lfu_cache_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lfu_req_if.sink         i_req,
    lfu_rsp_if.source       o_rsp
);

    lfu_pkg::t_dp_cmd cmd;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    lfu_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_req.func),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );

endmodule

/* tb/lfu_table_checker.sv */
// Request/response monitor for the LFU cache table: predicts each lookup and checks it in order.
module lfu_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lfu_req_if   i_req_mon,
    lfu_rsp_if   i_rsp_mon,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic   hit;
        t_value read_value;
        logic   evicted;
        t_key   evicted_key;
    } t_lookup_result;

    typedef struct packed {
        logic           func;
        t_key           key;
        t_lookup_result res;
    } t_lookup_expect;

    // Shadow copy of the table; age 0 marks the newest insertion.
    logic   slot_used  [ENTRIES];
    t_key   slot_key   [ENTRIES];
    t_value slot_value [ENTRIES];
    t_count slot_uses  [ENTRIES];
    t_idx   slot_age   [ENTRIES];

    t_lookup_expect lookups_in_flight[$];
    int fail_total      = 0;
    int in_flight_count = 0;

    assign o_mismatches  = fail_total;
    assign o_outstanding = in_flight_count;

    initial begin
        foreach (slot_used[i]) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
            slot_age[i]   = '0;
        end
    end

    function automatic t_lookup_result predict_lookup(logic func, t_key key, t_value value);
        t_lookup_result res;
        int   match;
        int   victim;
        int   filled;
        t_idx gone_age;
        logic placed;
        res    = '0;
        match  = -1;
        victim = -1;
        filled = 0;
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (match < 0 && slot_used[i] && slot_key[i] == key)
                match = i;
        if (match >= 0) begin
            res.hit = 1'b1;
            if (func == FUNC_GET)
                res.read_value = slot_value[match];
            else
                slot_value[match] = value;
            if (slot_uses[match] != COUNT_MAX)
                slot_uses[match] = slot_uses[match] + COUNT_ONE;
            return res;
        end
        if (func == FUNC_GET)
            return res;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
                filled++;
        // Full table: drop the least used entry, the newest one among ties.
        if (filled >= ENTRIES) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_age[i] < slot_age[victim])))
                    victim = i;
            end
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[victim];
            gone_age        = slot_age[victim];
            slot_used[victim] = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] > gone_age)
                    slot_age[i] = slot_age[i] - 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && !slot_used[i]) begin
                for (int j = 0; j < ENTRIES; j++)
                    if (slot_used[j])
                        slot_age[j] = slot_age[j] + 1'b1;
                slot_used[i]  = 1'b1;
                slot_key[i]   = key;
                slot_value[i] = value;
                slot_uses[i]  = COUNT_ONE;
                slot_age[i]   = '0;
                placed        = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup_expect want;
        t_lookup_result seen;
        if (i_rst_n) begin
            // Check the response first: it always belongs to an earlier request.
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen.hit         = i_rsp_mon.hit;
                seen.read_value  = i_rsp_mon.read_value;
                seen.evicted     = i_rsp_mon.evicted;
                seen.evicted_key = i_rsp_mon.evicted_key;
                if (lookups_in_flight.size() == 0) begin
                    if (fail_total < REPORT_LIMIT)
                        $display("%0t: response without request: hit %0b read_value %h evicted %0b evicted_key %h",
                                 $time, seen.hit, seen.read_value, seen.evicted,
                                 seen.evicted_key);
                    fail_total++;
                end else begin
                    want = lookups_in_flight.pop_front();
                    if (seen !== want.res) begin
                        if (fail_total < REPORT_LIMIT)
                            $display("%0t: %s key %h: expected hit %0b read_value %h evicted %0b evicted_key %h, got hit %0b read_value %h evicted %0b evicted_key %h",
                                     $time, (want.func == FUNC_PUT) ? "put" : "get", want.key,
                                     want.res.hit, want.res.read_value, want.res.evicted,
                                     want.res.evicted_key, seen.hit, seen.read_value,
                                     seen.evicted, seen.evicted_key);
                        fail_total++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                want.func = i_req_mon.func;
                want.key  = i_req_mon.key;
                want.res  = predict_lookup(i_req_mon.func, i_req_mon.key, i_req_mon.value);
                lookups_in_flight.push_back(want);
            end
            in_flight_count <= lookups_in_flight.size();
        end
    end

endmodule

/* tb/tb_lfu_cache_table.sv */
// Testbench top for the LFU cache table: request stimulus, response flow control and verdict.
module tb_lfu_cache_table;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOT_GETS        = 24;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 130;
    localparam int POOL_MAX        = 8;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;
    logic send_gaps_on;
    logic rsp_stalls_on;
    int   hold_off_asks = 0;

    lfu_req_if req_ch();
    lfu_rsp_if rsp_ch();

    lfu_cache_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lfu_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Response side flow control.
    initial begin
        int hold_off_seen;
        hold_off_seen = 0;
        rsp_ch.ready  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_seen != hold_off_asks) begin
                // Long hold-off: let the block fill up and stall its request side.
                hold_off_seen = hold_off_asks;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
    end

    // Present one request and hold it until accepted; valid stays high afterwards.
    task automatic send_request(input logic func, input t_key key, input t_value value);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.key   <= key;
        req_ch.value <= value;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // Drop valid and wait until every request has its response.
    task automatic pause_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_key key_pool [POOL_MAX];
        int   pool_size;
        int   put_pct;
        t_key pick_key;
        logic pick_put;

        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_GET;
        req_ch.key    = '0;
        req_ch.value  = '0;
        i_rst_n       = 1'b0;
        send_gaps_on  = 1'b1;
        rsp_stalls_on = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table miss, key/value extremes, hits, put hit, tied evictions.
        send_request(FUNC_GET, 16'h0000, 32'h0000_0000);
        send_request(FUNC_PUT, 16'h0000, 32'h0000_0000);
        send_request(FUNC_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 16'hFFFF, 32'h0000_0000);
        send_request(FUNC_GET, 16'h0000, 32'hFFFF_FFFF);
        send_request(FUNC_PUT, 16'h0000, 32'hA5A5_A5A5);
        send_request(FUNC_PUT, 16'h1234, 32'h0123_4567);
        send_request(FUNC_PUT, 16'h8001, 32'h89AB_CDEF);
        send_request(FUNC_PUT, 16'h4321, 32'h5A5A_5A5A);
        send_request(FUNC_PUT, 16'h5555, 32'h8000_0001);
        send_request(FUNC_GET, 16'h1234, 32'h0000_0000);
        send_request(FUNC_PUT, 16'h6666, 32'h7FFF_FFFF);
        send_request(FUNC_GET, 16'h4321, 32'h0000_0000);
        send_request(FUNC_GET, 16'h0000, 32'hDEAD_BEEF);
        send_request(FUNC_GET, 16'h6666, 32'h0000_0000);
        send_request(FUNC_PUT, 16'h7777, 32'h1111_1111);
        send_request(FUNC_GET, 16'hFFFF, 32'h0000_0000);
        pause_until_drained();

        // Hot key: hammer one key, then make sure it survives evictions.
        send_gaps_on  = 1'b0;
        rsp_stalls_on = 1'b0;
        send_request(FUNC_PUT, 16'h0F0F, 32'h1357_9BDF);
        repeat (HOT_GETS) send_request(FUNC_GET, 16'h0F0F, '0);
        send_request(FUNC_PUT, 16'h0F0F, 32'h2468_ACE0);
        for (int n = 0; n < 6; n++)
            send_request(FUNC_PUT, t_key'(16'hC000 + n), t_value'(n));
        send_request(FUNC_GET, 16'h0F0F, '0);
        pause_until_drained();

        // Random: working sets of a few keys to mix hits and evictions, plus stray keys.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_gaps_on  = (p != 3);
            rsp_stalls_on = (p != 3);
            if (p == 1 || p == 5)
                hold_off_asks++;
            pool_size = $urandom_range(3, POOL_MAX);
            put_pct   = $urandom_range(20, 70);
            foreach (key_pool[k])
                key_pool[k] = t_key'($urandom_range(0, 65535));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 11) == 0)
                    pick_key = t_key'($urandom_range(0, 65535));
                else
                    pick_key = key_pool[$urandom_range(0, pool_size - 1)];
                pick_put = ($urandom_range(0, 99) < put_pct);
                send_request(pick_put ? FUNC_PUT : FUNC_GET, pick_key, t_value'($urandom));
            end
            if (p % 2 == 1)
                pause_until_drained();
        end
        pause_until_drained();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
